### rtl/ctgr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time gain functions for the
// color temperature gamma ramp. No dependencies.
package ctgr_pkg;

	localparam int unsigned TEMP_W         = 10;
	localparam int unsigned INDEX_W        = 12;
	localparam int unsigned WORD_W         = 16;
	localparam int unsigned SIZE_W         = 13;
	localparam int unsigned LAST_W         = 13;
	localparam int unsigned NUM_W          = INDEX_W + WORD_W + 2;
	localparam int unsigned DEN_W          = LAST_W + 1;
	localparam int unsigned NUM_CH         = 3;

	localparam int unsigned TEMP_STEP_K    = 10;
	localparam int unsigned KELVIN_MIN     = 1900;
	localparam int unsigned KELVIN_NEUTRAL = 6500;
	localparam int unsigned KELVIN_BLUE_CUT = 1900;
	localparam int unsigned BLUE_SHIFT_K   = 1000;
	localparam int unsigned TAB_N          = (KELVIN_NEUTRAL - KELVIN_MIN) / TEMP_STEP_K + 1;
	localparam int unsigned TAB_AW         = $clog2(TAB_N);

	localparam logic [63:0] GREEN_MUL = 64'd994708025861;
	localparam logic [63:0] GREEN_OFF = 64'd1611195681661;
	localparam logic [63:0] BLUE_MUL  = 64'd1385177312231;
	localparam logic [63:0] BLUE_OFF  = 64'd3050447927307;
	localparam logic [63:0] FULL64    = 64'd65535;
	localparam logic [63:0] LN_BASE   = 64'd100;
	localparam logic [WORD_W-1:0] WORD_FULL = {WORD_W{1'b1}};

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t               green;
		word_t               blue;
		logic [INDEX_W-1:0]  index;
		logic [LAST_W-1:0]   last;
	} gain_beat_t;

	typedef struct packed {
		logic [NUM_CH-1:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]             den;
	} num_beat_t;

	typedef struct packed {
		word_t blue;
		word_t green;
		word_t red;
	} ramp_words_t;

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
	                                          input int unsigned s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_q60(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = n;
		q = '0;
		for (int i = 0; i < 60; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atanh2_q60(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] sum;
		z    = frac_q60(n, d);
		z2   = mul_shift(z, z, 60);
		term = z;
		sum  = '0;
		for (int unsigned j = 1; j < 400; j += 2) begin
			if (term != 64'd0) begin
				sum  = sum + udiv64(term, 64'(j));
				term = mul_shift(term, z2, 60);
			end
		end
		return sum << 1;
	endfunction

	function automatic logic [63:0] ln_q60(input logic [63:0] p, input logic [63:0] q);
		int unsigned k;
		logic [63:0] qk;
		k = 0;
		for (int unsigned i = 0; i < 16; i++) begin
			if ((q << (i + 1)) <= p)
				k = i + 1;
		end
		qk = q << k;
		return 64'(k) * atanh2_q60(64'd1, 64'd3) + atanh2_q60(p - qk, p + qk);
	endfunction

	function automatic logic [63:0] fit_value(input logic [63:0] mul, input logic [63:0] off,
	                                          input logic [63:0] lnv);
		logic [63:0] prod;
		logic [63:0] o;
		prod = mul_shift(mul, lnv, 56);
		o    = off << 4;
		return (prod > o) ? prod - o : 64'd0;
	endfunction

	function automatic logic [63:0] gain_of(input logic [63:0] num, input logic [63:0] den);
		if (den == 64'd0 || num >= den)
			return FULL64;
		return udiv64((num << 1) * FULL64 + den, den << 1);
	endfunction

	localparam logic [63:0] GREEN_DEN =
		fit_value(GREEN_MUL, GREEN_OFF, ln_q60(64'(KELVIN_NEUTRAL), LN_BASE));
	localparam logic [63:0] BLUE_DEN =
		fit_value(BLUE_MUL, BLUE_OFF, ln_q60(64'(KELVIN_NEUTRAL - BLUE_SHIFT_K), LN_BASE));

	function automatic word_t green_gain(input int unsigned kelvin);
		logic [63:0] g;
		g = gain_of(fit_value(GREEN_MUL, GREEN_OFF, ln_q60(64'(kelvin), LN_BASE)), GREEN_DEN);
		return g[WORD_W-1:0];
	endfunction

	function automatic word_t blue_gain(input int unsigned kelvin);
		logic [63:0] g;
		if (kelvin <= KELVIN_BLUE_CUT)
			return '0;
		g = gain_of(fit_value(BLUE_MUL, BLUE_OFF,
		                      ln_q60(64'(kelvin - BLUE_SHIFT_K), LN_BASE)), BLUE_DEN);
		return g[WORD_W-1:0];
	endfunction

endpackage

### rtl/ctgr_gain_rom.sv
`timescale 1ns / 1ps
// Stage 1: temperature clamp, gain table read and index clamp.
// Depends on ctgr_pkg for the table functions and beat types.
module ctgr_gain_rom (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ctgr_pkg::TEMP_W-1:0]       temperature_tens,
	input  logic [ctgr_pkg::INDEX_W-1:0]      ramp_index,
	input  logic [ctgr_pkg::LAST_W-1:0]       last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ctgr_pkg::gain_beat_t              out_beat
);

	localparam logic [ctgr_pkg::TEMP_W-1:0] T_MIN =
		ctgr_pkg::TEMP_W'(ctgr_pkg::KELVIN_MIN / ctgr_pkg::TEMP_STEP_K);
	localparam logic [ctgr_pkg::TEMP_W-1:0] T_MAX =
		ctgr_pkg::TEMP_W'(ctgr_pkg::KELVIN_NEUTRAL / ctgr_pkg::TEMP_STEP_K);

	ctgr_pkg::word_t green_rom [ctgr_pkg::TAB_N];
	ctgr_pkg::word_t blue_rom  [ctgr_pkg::TAB_N];

	for (genvar i = 0; i < ctgr_pkg::TAB_N; i++) begin : g_tab
		localparam int unsigned KELVIN = ctgr_pkg::KELVIN_MIN + i * ctgr_pkg::TEMP_STEP_K;
		localparam ctgr_pkg::word_t GREEN_G = ctgr_pkg::green_gain(KELVIN);
		localparam ctgr_pkg::word_t BLUE_G  = ctgr_pkg::blue_gain(KELVIN);
		assign green_rom[i] = GREEN_G;
		assign blue_rom[i]  = BLUE_G;
	end

	logic [ctgr_pkg::TEMP_W-1:0]  t_clamp;
	logic [ctgr_pkg::TAB_AW-1:0]  addr;
	logic [ctgr_pkg::LAST_W-1:0]  last_eff;
	logic [ctgr_pkg::INDEX_W-1:0] index_eff;
	logic                         valid_s1;
	ctgr_pkg::gain_beat_t         beat_s1;

	always_comb begin
		priority if (temperature_tens < T_MIN)
			t_clamp = T_MIN;
		else if (temperature_tens > T_MAX)
			t_clamp = T_MAX;
		else
			t_clamp = temperature_tens;
		addr = ctgr_pkg::TAB_AW'(t_clamp - T_MIN);

		// a one-entry ramp gives the gain: same as index 1 over last 1
		if (last == '0) begin
			last_eff  = ctgr_pkg::LAST_W'(1);
			index_eff = ctgr_pkg::INDEX_W'(1);
		end else begin
			last_eff = last;
			if (ctgr_pkg::LAST_W'(ramp_index) > last)
				index_eff = last[ctgr_pkg::INDEX_W-1:0];
			else
				index_eff = ramp_index;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1.green <= green_rom[addr];
			beat_s1.blue  <= blue_rom[addr];
			beat_s1.index <= index_eff;
			beat_s1.last  <= last_eff;
		end
	end

	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

endmodule

### rtl/ctgr_scale.sv
`timescale 1ns / 1ps
// Stage 2: index times gain, rounding numerator and doubled divisor.
// Depends on ctgr_pkg for the beat types.
module ctgr_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ctgr_pkg::gain_beat_t in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ctgr_pkg::num_beat_t  out_beat
);

	logic [ctgr_pkg::NUM_W-1:0] idx_w;
	logic [ctgr_pkg::NUM_W-1:0] last_w;
	logic [ctgr_pkg::NUM_W-1:0] prod_r;
	logic [ctgr_pkg::NUM_W-1:0] prod_g;
	logic [ctgr_pkg::NUM_W-1:0] prod_b;
	logic                       valid_s2;
	ctgr_pkg::num_beat_t        beat_s2;

	always_comb begin
		idx_w  = ctgr_pkg::NUM_W'(in_beat.index);
		last_w = ctgr_pkg::NUM_W'(in_beat.last);
		prod_r = idx_w * ctgr_pkg::NUM_W'(ctgr_pkg::WORD_FULL);
		prod_g = idx_w * ctgr_pkg::NUM_W'(in_beat.green);
		prod_b = idx_w * ctgr_pkg::NUM_W'(in_beat.blue);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s2.num[ctgr_pkg::CH_RED]   <= (prod_r << 1) + last_w;
			beat_s2.num[ctgr_pkg::CH_GREEN] <= (prod_g << 1) + last_w;
			beat_s2.num[ctgr_pkg::CH_BLUE]  <= (prod_b << 1) + last_w;
			beat_s2.den                     <= {in_beat.last, 1'b0};
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

### rtl/ctgr_ramp_div.sv
`timescale 1ns / 1ps
// Stages 3 and up: restoring divider, one quotient bit per stage, three channels.
// Depends on ctgr_pkg for widths and beat types.
module ctgr_ramp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ctgr_pkg::num_beat_t   in_beat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ctgr_pkg::ramp_words_t out_words
);

	localparam int unsigned NST = ctgr_pkg::WORD_W;

	typedef struct packed {
		logic [ctgr_pkg::NUM_CH-1:0][ctgr_pkg::NUM_W-1:0]  rem;
		logic [ctgr_pkg::NUM_CH-1:0][ctgr_pkg::WORD_W-1:0] quo;
		logic [ctgr_pkg::DEN_W-1:0]                        den;
	} div_beat_t;

	logic      valid_s [NST];
	div_beat_t stg_s   [NST];
	logic      rdy     [NST+1];
	div_beat_t src     [NST];
	logic      src_v   [NST];

	assign rdy[NST] = out_ready;
	assign src[0].rem = in_beat.num;
	assign src[0].quo = '0;
	assign src[0].den = in_beat.den;
	assign src_v[0]   = in_valid;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam int unsigned B = NST - 1 - k;
		logic [ctgr_pkg::NUM_W-1:0] trial;
		div_beat_t                  nxt;

		if (k > 0) begin : g_link
			assign src[k]   = stg_s[k-1];
			assign src_v[k] = valid_s[k-1];
		end

		assign rdy[k] = !valid_s[k] || rdy[k+1];
		assign trial  = ctgr_pkg::NUM_W'(src[k].den) << B;

		always_comb begin
			nxt = src[k];
			for (int c = 0; c < ctgr_pkg::NUM_CH; c++) begin
				if (src[k].rem[c] >= trial) begin
					nxt.rem[c]    = src[k].rem[c] - trial;
					nxt.quo[c][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (src_v[k] && rdy[k]) begin
				stg_s[k] <= nxt;
			end
		end
	end

	assign in_ready        = rdy[0];
	assign out_valid       = valid_s[NST-1];
	assign out_words.red   = stg_s[NST-1].quo[ctgr_pkg::CH_RED];
	assign out_words.green = stg_s[NST-1].quo[ctgr_pkg::CH_GREEN];
	assign out_words.blue  = stg_s[NST-1].quo[ctgr_pkg::CH_BLUE];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[NST-1] |->
			stg_s[NST-1].rem[ctgr_pkg::CH_RED]   < ctgr_pkg::NUM_W'(stg_s[NST-1].den) &&
			stg_s[NST-1].rem[ctgr_pkg::CH_GREEN] < ctgr_pkg::NUM_W'(stg_s[NST-1].den) &&
			stg_s[NST-1].rem[ctgr_pkg::CH_BLUE]  < ctgr_pkg::NUM_W'(stg_s[NST-1].den))
		else $error("divider remainder not below divisor");

	a_red_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[NST-1] |-> out_words.red >= out_words.green && out_words.red >= out_words.blue)
		else $error("red word below another channel");

	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && !rdy[1] |=> valid_s[0] && $stable(stg_s[0]))
		else $error("first divider stage lost a stalled beat");

endmodule

### rtl/color_temperature_gamma_ramp.sv
`timescale 1ns / 1ps
// Pipeline: registered gain table read, multiply, then 16 divider stages, one quotient
// bit each, from s_axis transfer to m_axis_tvalid. Throughput: one item per cycle
// while m_axis_tready is high; each stage holds on stall and accepts into any empty slot.
// Reset (arst_n low, asynchronous): pipeline empties, ramp_size returns to 256.
// Depends on ctgr_pkg, ctgr_gain_rom, ctgr_scale, ctgr_ramp_div.
module color_temperature_gamma_ramp #(
	parameter int MAX_RAMP = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,       // ramp_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // temperature_tens [9:0], ramp_index [21:10]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // red_word [15:0], green_word [31:16], blue_word [47:32]
);

	localparam int RESET_LAST = ((MAX_RAMP < 256) ? MAX_RAMP : 256) - 1;

	logic [ctgr_pkg::LAST_W-1:0] last_q;
	logic [ctgr_pkg::LAST_W-1:0] last_next;
	logic                        rom_valid;
	logic                        rom_ready;
	ctgr_pkg::gain_beat_t        rom_beat;
	logic                        scl_valid;
	logic                        scl_ready;
	ctgr_pkg::num_beat_t         scl_beat;
	ctgr_pkg::ramp_words_t       words;

	always_comb begin
		priority if (cfg_data == '0)
			last_next = '0;
		else if (17'(cfg_data) > 17'(MAX_RAMP))
			last_next = ctgr_pkg::LAST_W'(MAX_RAMP - 1);
		else
			last_next = cfg_data - ctgr_pkg::LAST_W'(1);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= ctgr_pkg::LAST_W'(RESET_LAST);
		end else if (cfg_valid && cfg_ready) begin
			last_q <= last_next;
		end
	end

	ctgr_gain_rom u_rom (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.temperature_tens (s_axis_tdata[9:0]),
		.ramp_index       (s_axis_tdata[21:10]),
		.last             (last_q),
		.out_valid        (rom_valid),
		.out_ready        (rom_ready),
		.out_beat         (rom_beat)
	);

	ctgr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rom_valid),
		.in_ready  (rom_ready),
		.in_beat   (rom_beat),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.out_beat  (scl_beat)
	);

	ctgr_ramp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.in_beat   (scl_beat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_words (words)
	);

	assign m_axis_tdata = {words.blue, words.green, words.red};

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> 17'(last_q) <= 17'(MAX_RAMP - 1))
		else $error("ramp last entry beyond maximum ramp size");

endmodule

### tb/tb_color_temperature_gamma_ramp.sv
`timescale 1ns / 1ps
// Self-checking bench for color_temperature_gamma_ramp: streams temperature/index
// transfers under random gaps and output stalls, checks every ramp word set against
// a bit-exact fixed-point gain predictor. Depends on ctgr_pkg and the RTL.
module tb_color_temperature_gamma_ramp;

	localparam int unsigned     TEMP_STEP     = 10;
	localparam int unsigned     K_LOW         = 1900;
	localparam int unsigned     K_WHITE       = 6500;
	localparam int unsigned     BLUE_OFFSET_K = 1000;
	localparam int unsigned     SLOTS         = (K_WHITE - K_LOW) / TEMP_STEP + 1;
	localparam int unsigned     RAMP_LIMIT    = 4096;
	localparam longint unsigned G_SLOPE       = 64'd994708025861;
	localparam longint unsigned G_OFFSET      = 64'd1611195681661;
	localparam longint unsigned B_SLOPE       = 64'd1385177312231;
	localparam longint unsigned B_OFFSET      = 64'd3050447927307;
	localparam longint unsigned FULL_SCALE    = 64'd65535;
	localparam longint unsigned LOG_BASE      = 64'd100;

	typedef struct {
		ctgr_pkg::word_t red;
		ctgr_pkg::word_t green;
		ctgr_pkg::word_t blue;
	} ramp_set_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data      = '0;      // ramp_size
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;      // temperature_tens [9:0], ramp_index [21:10]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;            // red_word [15:0], green_word [31:16], blue_word [47:32]

	ctgr_pkg::word_t green_gain_tab [SLOTS];
	ctgr_pkg::word_t blue_gain_tab  [SLOTS];
	logic [12:0] ramp_size_now = 13'd256;
	ramp_set_t   pending_ramps[$];
	int unsigned items_sent    = 0;
	int unsigned ramps_checked = 0;
	int unsigned cfg_writes    = 0;
	int unsigned mismatches    = 0;
	bit          send_steady   = 1'b0;
	bit          recv_steady   = 1'b0;
	int unsigned stall_left    = 0;

	color_temperature_gamma_ramp DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("color_temperature_gamma_ramp test failed");
		$finish;
	end

	function automatic longint unsigned mulhi(input longint unsigned a,
	                                          input longint unsigned b, input int unsigned s);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return 64'(p >> s);
	endfunction

	function automatic longint unsigned q60_ratio(input longint unsigned n,
	                                              input longint unsigned d);
		logic [127:0] w;
		w = 128'(n) << 60;
		return 64'(w / 128'(d));
	endfunction

	function automatic longint unsigned two_atanh(input longint unsigned n,
	                                              input longint unsigned d);
		longint unsigned z, z2, term, sum;
		z    = q60_ratio(n, d);
		z2   = mulhi(z, z, 60);
		term = z;
		sum  = 0;
		for (longint unsigned j = 1; term != 0 && j < 400; j += 2) begin
			sum  = sum + term / j;
			term = mulhi(term, z2, 60);
		end
		return sum << 1;
	endfunction

	function automatic longint unsigned log_q60(input longint unsigned p, input longint unsigned q,
	                                            input longint unsigned ln2);
		int unsigned     k;
		longint unsigned qk;
		k = 0;
		while ((q << (k + 1)) <= p)
			k++;
		qk = q << k;
		return 64'(k) * ln2 + two_atanh(p - qk, p + qk);
	endfunction

	function automatic longint unsigned fit(input longint unsigned slope,
	                                        input longint unsigned offset, input longint unsigned lnv);
		longint unsigned prod, o;
		prod = mulhi(slope, lnv, 56);
		o    = offset << 4;
		return (prod > o) ? prod - o : 64'd0;
	endfunction

	function automatic ctgr_pkg::word_t gain_ratio(input longint unsigned num,
	                                               input longint unsigned den);
		if (den == 0 || num >= den)
			return ctgr_pkg::word_t'(FULL_SCALE);
		return ctgr_pkg::word_t'((64'd2 * num * FULL_SCALE + den) / (64'd2 * den));
	endfunction

	task automatic build_gain_table;
		longint unsigned ln2, g_ref, b_ref, kel;
		ln2   = two_atanh(1, 3);
		g_ref = fit(G_SLOPE, G_OFFSET, log_q60(64'(K_WHITE), LOG_BASE, ln2));
		b_ref = fit(B_SLOPE, B_OFFSET, log_q60(64'(K_WHITE - BLUE_OFFSET_K), LOG_BASE, ln2));
		for (int s = 0; s < SLOTS; s++) begin
			kel = 64'(K_LOW + s * TEMP_STEP);
			green_gain_tab[s] = gain_ratio(fit(G_SLOPE, G_OFFSET, log_q60(kel, LOG_BASE, ln2)),
			                               g_ref);
			if (kel <= K_LOW)
				blue_gain_tab[s] = '0;
			else
				blue_gain_tab[s] = gain_ratio(fit(B_SLOPE, B_OFFSET,
				                                  log_q60(kel - BLUE_OFFSET_K, LOG_BASE, ln2)), b_ref);
		end
	endtask

	function automatic int unsigned size_limit();
		if (ramp_size_now == 0)
			return 1;
		if (ramp_size_now > RAMP_LIMIT)
			return RAMP_LIMIT;
		return 32'(ramp_size_now);
	endfunction

	function automatic ctgr_pkg::word_t ramp_entry(input ctgr_pkg::word_t g,
	                                               input longint unsigned idx,
	                                               input longint unsigned size);
		longint unsigned last;
		if (size <= 1)
			return g;
		last = size - 1;
		if (idx > last)
			idx = last;
		return ctgr_pkg::word_t'((64'd2 * idx * g + last) / (64'd2 * last));
	endfunction

	function automatic ramp_set_t predict_ramp(input logic [9:0] temp, input logic [11:0] idx);
		longint unsigned kel, size;
		int unsigned     slot;
		ramp_set_t       r;
		kel = 64'(temp) * TEMP_STEP;
		if (kel < K_LOW)
			kel = 64'(K_LOW);
		if (kel > K_WHITE)
			kel = 64'(K_WHITE);
		slot    = 32'((kel - K_LOW) / TEMP_STEP);
		size    = 64'(size_limit());
		r.red   = ramp_entry(ctgr_pkg::word_t'(FULL_SCALE), 64'(idx), size);
		r.green = ramp_entry(green_gain_tab[slot], 64'(idx), size);
		r.blue  = ramp_entry(blue_gain_tab[slot], 64'(idx), size);
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [9:0] rand_temp();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return 10'($urandom_range(190, 650));
		if (roll == 7)
			return ($urandom_range(0, 1) != 0) ? 10'($urandom_range(189, 191))
			                                   : 10'($urandom_range(649, 651));
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic logic [11:0] rand_index();
		int unsigned roll, span;
		roll = $urandom_range(0, 9);
		span = size_limit();
		if (roll < 7)
			return 12'($urandom_range(0, span - 1));
		if (roll == 7)
			return 12'(span - 1);
		if (roll == 8)
			return 12'd0;
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
	                               input longint unsigned got);
		$display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want, got, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin
		ramp_set_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ramps.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 64'(m_axis_tdata));
			end else begin
				want = pending_ramps.pop_front();
				if (m_axis_tdata[15:0] !== want.red)
					report_mismatch("red_word", 64'(want.red), 64'(m_axis_tdata[15:0]));
				if (m_axis_tdata[31:16] !== want.green)
					report_mismatch("green_word", 64'(want.green), 64'(m_axis_tdata[31:16]));
				if (m_axis_tdata[47:32] !== want.blue)
					report_mismatch("blue_word", 64'(want.blue), 64'(m_axis_tdata[47:32]));
				ramps_checked++;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!recv_steady && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
		if ($urandom_range(0, 255) == 0)
			recv_steady = ($urandom_range(0, 2) == 0);
	end

	task automatic send_item(input logic [9:0] temp, input logic [11:0] idx);
		int unsigned gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, idx, temp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_ramps.push_back(predict_ramp(temp, idx));
		items_sent++;
	endtask

	task automatic drain_results;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_ramps.size() != 0) @(posedge clk);
	endtask

	task automatic write_ramp_size(input logic [12:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid     <= 1'b0;
		ramp_size_now = value;
		cfg_writes++;
	endtask

	// ramp_size still at its reset value of 256
	task automatic test_reset_defaults;
		send_item(10'd190, 12'd0);
		send_item(10'd190, 12'd255);
		send_item(10'd650, 12'd255);
		send_item(10'd650, 12'd128);
		send_item(10'd0, 12'd100);
		send_item(10'd1023, 12'd4095);
		send_item(10'd189, 12'd200);
		send_item(10'd191, 12'd17);
		send_item(10'd651, 12'd254);
		send_item(10'd200, 12'd256);
		send_item(10'd400, 12'd64);
		send_item(10'd555, 12'd3);
	endtask

	task automatic test_size_extremes;
		logic [12:0] sizes [4];
		sizes = '{13'd0, 13'd1, 13'd2, 13'd8191};
		for (int i = 0; i < 4; i++) begin
			write_ramp_size(sizes[i]);
			send_item(rand_temp(), 12'd0);
			send_item(rand_temp(), 12'(size_limit() - 1));
			send_item((i % 2 == 0) ? 10'd1023 : 10'd0, 12'd4095);
		end
	endtask

	task automatic test_random_stream;
		logic [12:0] phase_size [6];
		logic [9:0]  temp;
		logic [11:0] idx;
		int unsigned span, start;
		bit          sweep;
		phase_size[0] = 13'($urandom_range(2, 64));
		phase_size[1] = 13'($urandom_range(65, 4095));
		phase_size[2] = 13'd4096;
		phase_size[3] = 13'd1;
		phase_size[4] = 13'($urandom_range(0, 8191));
		phase_size[5] = 13'd256;
		for (int p = 0; p < 6; p++) begin
			write_ramp_size(phase_size[p]);
			for (int chunk = 0; chunk < 15; chunk++) begin
				if (chunk == 7)
					drain_results();
				send_steady = ($urandom_range(0, 4) == 0);
				sweep       = ($urandom_range(0, 2) == 0);
				temp        = rand_temp();
				span        = size_limit();
				start       = $urandom_range(0, span - 1);
				for (int i = 0; i < 10; i++) begin
					if (sweep) begin
						idx = 12'((start + i) % span);
					end else begin
						temp = rand_temp();
						idx  = rand_index();
					end
					send_item(temp, idx);
				end
			end
		end
		send_steady = 1'b0;
	endtask

	initial begin
		int unsigned waited;
		build_gain_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_size_extremes();
		test_random_stream();

		s_axis_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_ramps.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_ramps.size() != 0)
			report_mismatch("ramp sets never delivered", 64'(pending_ramps.size()), 0);

		$display("Run covered %0d transfers in, %0d ramp sets checked, %0d ramp_size writes",
		         items_sent, ramps_checked, cfg_writes);
		$display("Sizes 0, 1, 2, 4096 and 8191, full temperature and index fields, gaps and stalls");
		if (mismatches == 0) begin
			$display("color_temperature_gamma_ramp test passed");
		end else begin
			$display("color_temperature_gamma_ramp test failed");
		end
		$finish;
	end

endmodule

### color_temperature_gamma_ramp.f
rtl/ctgr_pkg.sv
rtl/ctgr_gain_rom.sv
rtl/ctgr_scale.sv
rtl/ctgr_ramp_div.sv
rtl/color_temperature_gamma_ramp.sv
tb/tb_color_temperature_gamma_ramp.sv
